// ===== hw/rtl/bpfa_pkg.sv =====
package bpfa_pkg;

    // Fixed field widths of the streams and the configuration register.
    localparam int KIND_W      = 2;
    localparam int ADDR_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 14;
    localparam int RES_W       = 14;
    localparam int PAGE_SHIFT  = 12;
    localparam int S_TDATA_W   = ADDR_W;
    localparam int S_TUSER_W   = KIND_W;
    localparam int M_TDATA_W   = STATUS_W + ADDR_W + COUNT_W;

    localparam int             PAGE_COUNT_DEF = 8192;
    localparam logic [RES_W-1:0] RES_RESET    = RES_W'(512);
    localparam logic [7:0]     FULL_BYTE      = 8'hFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_INIT  = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_OUT     = 2'd1,
        ST_INVALID = 2'd2,
        ST_DOUBLE  = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch;
        logic    init_start;
        logic    init_wr;
        logic    init_end;
        logic    scan_start;
        logic    scan_read;
        logic    alloc_commit;
        logic    free_read;
        logic    free_commit;
        logic    ld_res;
        status_t res_status;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic sweep_last;
        logic rd_valid;
        logic rd_hit;
        logic rd_last;
        logic free_bad;
        logic free_used;
    } sts_t;

endpackage

// ===== hw/rtl/bpfa_dpath.sv =====
module bpfa_dpath import bpfa_pkg::*; #(
    parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [RES_W-1:0]     cfg_wr_data,
    input  logic [ADDR_W-1:0]    in_address,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int MAP_BYTES = (PAGE_COUNT + 7) / 8;
    localparam int MAP_AW    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CNT_W     = $clog2(PAGE_COUNT + 1);
    localparam int PAGE_W    = ADDR_W - PAGE_SHIFT;

    // Index of the lowest clear bit of a byte.
    function automatic logic [2:0] lowest_zero(input logic [7:0] b);
        logic [2:0] idx;
        idx = 3'd0;
        for (int j = 7; j >= 0; j--) begin
            if (!b[j]) begin
                idx = 3'(j);
            end
        end
        return idx;
    endfunction

    logic [7:0]          mem [MAP_BYTES];

    logic [RES_W-1:0]    reserved_reg;
    logic [CNT_W-1:0]    res_lim_reg, res_lim_next;
    logic [MAP_AW-1:0]   sweep_reg;
    logic [MAP_AW-1:0]   scan_reg;
    logic [MAP_AW-1:0]   rd_addr_reg;
    logic [MAP_AW-1:0]   hint_reg;
    logic [7:0]          rd_data_reg;
    logic                rd_valid_reg;
    logic [CNT_W-1:0]    free_pages_reg, free_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [ADDR_W-1:0]   m_addr_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    logic [7:0]          init_byte;
    logic [2:0]          alloc_idx;
    logic [7:0]          alloc_mask;
    logic [ADDR_W-1:0]   alloc_addr;
    logic [PAGE_W-1:0]   free_page;
    logic [MAP_AW-1:0]   free_byte;
    logic [7:0]          free_mask;
    logic                free_bad;
    logic                mem_we, mem_re;
    logic [MAP_AW-1:0]   mem_wa, mem_ra;
    logic [7:0]          mem_wd;

    assign res_lim_next = (32'(reserved_reg) > 32'(PAGE_COUNT)) ? CNT_W'(PAGE_COUNT)
                                                                : CNT_W'(reserved_reg);

    // A bit is set when its page lies below the reserved limit or past the map.
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            init_byte[j] = (32'({sweep_reg, 3'(j)}) < 32'(res_lim_reg)) ||
                           (32'({sweep_reg, 3'(j)}) >= 32'(PAGE_COUNT));
        end
    end

    assign alloc_idx  = lowest_zero(rd_data_reg);
    assign alloc_mask = 8'd1 << alloc_idx;
    assign alloc_addr = 32'({rd_addr_reg, alloc_idx}) << PAGE_SHIFT;

    assign free_page  = addr_reg[ADDR_W-1:PAGE_SHIFT];
    assign free_byte  = free_page[MAP_AW+2:3];
    assign free_mask  = 8'd1 << free_page[2:0];
    assign free_bad   = 32'(free_page) >= 32'(PAGE_COUNT);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = sweep_reg;
        mem_wd = init_byte;
        mem_re = 1'b0;
        mem_ra = scan_reg;
        if (cmd.init_wr) begin
            mem_we = 1'b1;
        end else if (cmd.alloc_commit) begin
            mem_we = 1'b1;
            mem_wa = rd_addr_reg;
            mem_wd = rd_data_reg | alloc_mask;
        end else if (cmd.free_commit) begin
            mem_we = 1'b1;
            mem_wa = free_byte;
            mem_wd = rd_data_reg & ~free_mask;
        end
        if (cmd.scan_read) begin
            mem_re = 1'b1;
        end else if (cmd.free_read) begin
            mem_re = 1'b1;
            mem_ra = free_byte;
        end
    end

    always_comb begin
        free_next = free_pages_reg;
        if (cmd.init_end) begin
            free_next = CNT_W'(PAGE_COUNT) - res_lim_reg;
        end else if (cmd.alloc_commit) begin
            free_next = free_pages_reg - CNT_W'(1);
        end else if (cmd.free_commit) begin
            free_next = free_pages_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
            rd_addr_reg <= mem_ra;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_reg <= RES_RESET;
            rd_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                reserved_reg <= cfg_wr_data;
            end
            if (cmd.scan_start) begin
                rd_valid_reg <= 1'b0;
            end else if (cmd.scan_read) begin
                rd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        free_pages_reg <= free_next;
        if (cmd.latch) begin
            addr_reg <= in_address;
        end
        if (cmd.init_start) begin
            res_lim_reg <= res_lim_next;
            sweep_reg   <= '0;
        end else if (cmd.init_wr) begin
            sweep_reg   <= sweep_reg + MAP_AW'(1);
        end
        if (cmd.scan_start) begin
            scan_reg <= hint_reg;
        end else if (cmd.scan_read) begin
            scan_reg <= scan_reg + MAP_AW'(1);
        end
        if (cmd.init_end) begin
            hint_reg <= '0;
        end else if (cmd.alloc_commit) begin
            hint_reg <= rd_addr_reg;
        end else if (cmd.free_commit && (free_byte < hint_reg)) begin
            hint_reg <= free_byte;
        end
        if (cmd.ld_res) begin
            m_status_reg <= cmd.res_status;
            m_addr_reg   <= cmd.alloc_commit ? alloc_addr : '0;
            m_count_reg  <= COUNT_W'(free_next);
        end
    end

    assign sts.sweep_last = (32'(sweep_reg) == 32'(MAP_BYTES - 1));
    assign sts.rd_valid   = rd_valid_reg;
    assign sts.rd_hit     = (rd_data_reg != FULL_BYTE);
    assign sts.rd_last    = (32'(rd_addr_reg) == 32'(MAP_BYTES - 1));
    assign sts.free_bad   = free_bad;
    assign sts.free_used  = |(rd_data_reg & free_mask);

    assign m_tdata = {m_count_reg, m_addr_reg, m_status_reg};

`ifndef SYNTHESIS
    a_alloc_on_free_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_commit |-> rd_valid_reg && (rd_data_reg != FULL_BYTE))
        else $error("allocation committed without a clear bit in the read byte");

    a_free_only_used: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.free_commit |-> !free_bad && ((rd_data_reg & free_mask) != 8'd0))
        else $error("page released that was out of range or already clear");

    a_alloc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_commit |-> (free_pages_reg != '0))
        else $error("allocation found a clear bit while the free count is zero");

    a_result_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_res |=> (m_count_reg == COUNT_W'(free_pages_reg)))
        else $error("result count differs from the stored free count");
`endif

endmodule

// ===== hw/rtl/bpfa_ctrl.sv =====
module bpfa_ctrl import bpfa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [KIND_W-1:0]    s_kind,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output cmd_t                 cmd,
    input  sts_t                 sts
);

    typedef enum logic [2:0] {
        S_BOOT,
        S_SWEEP,
        S_INIT_END,
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_CHK,
        S_NOP_RES
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   boot_reg, boot_next;
    logic   out_free;
    logic   accept;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd        = '0;
        cmd.res_status = ST_OK;
        state_next = state_reg;
        boot_next  = boot_reg;
        case (state_reg)
            S_BOOT: begin
                cmd.init_start = 1'b1;
                state_next     = S_SWEEP;
            end
            S_SWEEP: begin
                cmd.init_wr = 1'b1;
                if (sts.sweep_last) begin
                    state_next = S_INIT_END;
                end
            end
            S_INIT_END: begin
                if (boot_reg) begin
                    cmd.init_end = 1'b1;
                    boot_next    = 1'b0;
                    state_next   = S_IDLE;
                end else if (out_free) begin
                    cmd.init_end = 1'b1;
                    cmd.ld_res   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    cmd.latch = 1'b1;
                    case (s_kind)
                        KIND_ALLOC: begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        KIND_FREE: begin
                            state_next = S_FREE_RD;
                        end
                        KIND_INIT: begin
                            cmd.init_start = 1'b1;
                            state_next     = S_SWEEP;
                        end
                        default: begin
                            state_next = S_NOP_RES;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (sts.rd_valid && sts.rd_hit) begin
                    if (out_free) begin
                        cmd.alloc_commit = 1'b1;
                        cmd.ld_res       = 1'b1;
                        state_next       = S_IDLE;
                    end
                end else if (sts.rd_valid && sts.rd_last) begin
                    if (out_free) begin
                        cmd.ld_res     = 1'b1;
                        cmd.res_status = ST_OUT;
                        state_next     = S_IDLE;
                    end
                end else begin
                    cmd.scan_read = 1'b1;
                end
            end
            S_FREE_RD: begin
                cmd.free_read = !sts.free_bad;
                state_next    = S_FREE_CHK;
            end
            S_FREE_CHK: begin
                if (out_free) begin
                    cmd.ld_res = 1'b1;
                    state_next = S_IDLE;
                    if (sts.free_bad) begin
                        cmd.res_status = ST_INVALID;
                    end else if (!sts.free_used) begin
                        cmd.res_status = ST_DOUBLE;
                    end else begin
                        cmd.free_commit = 1'b1;
                    end
                end
            end
            S_NOP_RES: begin
                if (out_free) begin
                    cmd.ld_res = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        m_tvalid_next = cmd.ld_res ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_BOOT;
            m_tvalid_reg <= 1'b0;
            boot_reg     <= 1'b1;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            boot_reg     <= boot_next;
        end
    end

`ifndef SYNTHESIS
    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_res |-> out_free)
        else $error("result loaded while the previous one is still pending");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted item did not start any work");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> m_tvalid_reg)
        else $error("pending result withdrawn before it was taken");
`endif

endmodule

// ===== hw/rtl/bitmap_page_frame_allocator.sv =====
// Channel   | Direction | Ports                            | Contents
// ----------+-----------+----------------------------------+-----------------------------------
// request   | in        | s_tvalid s_tready s_tdata s_tuser | kind in tuser, free address in tdata
// result    | out       | m_tvalid m_tready m_tdata         | status, page address, free count
// config    | in        | cfg_wr_en cfg_wr_data            | reserved page count, write only
//
// An allocation reads map bytes one per cycle, starting at the lowest byte that may hold a clear
// bit, until it finds one or reaches the last byte; at most MAP_BYTES bytes are read. A free
// reads the page's map byte and then checks it; an initialise writes one map byte per cycle.
// After reset the block sweeps the whole map once with s_tready low.
// A result waits in the output register while the next transfer is accepted; the block only
// stalls at the end of that next item if the earlier result has still not been taken.
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
    parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration: the reserved page count, written whenever the enable is high.
    input  logic                 cfg_wr_en,
    input  logic [RES_W-1:0]     cfg_wr_data,
    // Request stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] address
    input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] kind
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [1:0] status, [33:2] page_address,
                                            // [47:34] free page count
);

    // The controller sequences each request; the datapath holds the page map memory, the
    // free count, the scan pointers and the result register.
    cmd_t cmd;
    sts_t sts;

    bpfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    bpfa_dpath #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_address  (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .m_tdata     (m_tdata)
    );

endmodule
